>>> sv/cbt_pkg.sv
// cbt_pkg: shared types and constants of the camera bend tracking block
// configuration set, classified frame record, position codes, register indexes
// no dependencies
`default_nettype none

package cbt_pkg;

    localparam int SLOPE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam int THR_W      = 15;
    localparam int LIMIT_W    = 8;
    localparam int OFFSET_W   = 7;
    localparam int ANGLE_W    = 8;
    localparam int LOST_W     = 16;
    localparam int POS_W      = 2;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int QUEUE_DEPTH = 2;

    // camera position and decision codes
    localparam logic [POS_W-1:0] POS_STRAIGHT = 2'd0;
    localparam logic [POS_W-1:0] POS_LEFT     = 2'd1;
    localparam logic [POS_W-1:0] POS_RIGHT    = 2'd2;
    localparam logic [POS_W-1:0] DEC_NONE     = 2'd3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_BEND_LEFT_THR      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BEND_RIGHT_THR     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STRAIGHT_UPPER_THR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRAIGHT_LOWER_THR = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CONFIRM_LIMIT      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CHANGE_WAIT_LIMIT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CAM_ANGLE_OFFSET   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BEND_CHECK_ENABLE  = 3'd7;

    typedef struct packed {
        logic [THR_W-1:0]    bend_left_thr;
        logic [THR_W-1:0]    bend_right_thr;
        logic [THR_W-1:0]    straight_upper_thr;
        logic [THR_W-1:0]    straight_lower_thr;
        logic [LIMIT_W-1:0]  confirm_limit;
        logic [LIMIT_W-1:0]  change_wait_limit;
        logic [OFFSET_W-1:0] cam_angle_offset;
        logic                bend_check_enable;
    } cfg_t;

    // one frame after slope magnitude compares
    typedef struct packed {
        logic left_found;
        logic right_found;
        logic left_undef;
        logic right_undef;
        logic right_below_bend;   // |right| < bend left threshold
        logic left_below_bend;    // |left| < bend right threshold
        logic left_above_lower;
        logic left_above_upper;
        logic right_above_lower;
        logic right_above_upper;
    } class_t;

endpackage

`default_nettype wire

>>> sv/cbt_front.sv
// cbt_front: input stage, takes frame transactions and classifies the slopes
// against the thresholds into one registered record
// depends on cbt_pkg
`default_nettype none

module cbt_front #(
    parameter int SLOPE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          left_found,
    input  wire logic                          right_found,
    input  wire logic signed [SLOPE_WIDTH-1:0] left_slope,
    input  wire logic signed [SLOPE_WIDTH-1:0] right_slope,
    input  wire logic                          left_slope_undefined,
    input  wire logic                          right_slope_undefined,
    input  wire cbt_pkg::cfg_t                 cfg,
    input  wire logic                          q_full,
    output logic                               q_push,
    output cbt_pkg::class_t                    q_data
);

    import cbt_pkg::*;

    localparam int CMP_W = (SLOPE_WIDTH > THR_W) ? SLOPE_WIDTH : THR_W;

    logic [SLOPE_WIDTH-1:0] l_mag;
    logic [SLOPE_WIDTH-1:0] r_mag;
    logic [CMP_W-1:0]       l_cmp;
    logic [CMP_W-1:0]       r_cmp;
    class_t                 class_next;
    class_t                 class_reg;
    logic                   valid_reg;
    logic                   take;

    // exact two's complement magnitude, most negative value included
    assign l_mag = left_slope[SLOPE_WIDTH-1]  ? (~$unsigned(left_slope) + 1'b1)
                                              : $unsigned(left_slope);
    assign r_mag = right_slope[SLOPE_WIDTH-1] ? (~$unsigned(right_slope) + 1'b1)
                                              : $unsigned(right_slope);
    assign l_cmp = CMP_W'(l_mag);
    assign r_cmp = CMP_W'(r_mag);

    always_comb
    begin
        class_next.left_found        = left_found;
        class_next.right_found       = right_found;
        class_next.left_undef        = left_slope_undefined;
        class_next.right_undef       = right_slope_undefined;
        class_next.right_below_bend  = r_cmp < CMP_W'(cfg.bend_left_thr);
        class_next.left_below_bend   = l_cmp < CMP_W'(cfg.bend_right_thr);
        class_next.left_above_lower  = l_cmp > CMP_W'(cfg.straight_lower_thr);
        class_next.left_above_upper  = l_cmp > CMP_W'(cfg.straight_upper_thr);
        class_next.right_above_lower = r_cmp > CMP_W'(cfg.straight_lower_thr);
        class_next.right_above_upper = r_cmp > CMP_W'(cfg.straight_upper_thr);
    end

    assign full   = valid_reg && q_full;
    assign take   = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_data = class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (q_push)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            class_reg <= class_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/cbt_queue.sv
// cbt_queue: short queue of classified frames between front and back
// depends on cbt_pkg
`default_nettype none

module cbt_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire cbt_pkg::class_t data_in,
    output logic                 full,
    input  wire logic            pop,
    output cbt_pkg::class_t      data_out,
    output logic                 empty
);

    import cbt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    class_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

`default_nettype wire

>>> sv/cbt_back.sv
// cbt_back: tracking state, wait and confirmation counting, result register
// depends on cbt_pkg
`default_nettype none

module cbt_back #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_empty,
    input  wire cbt_pkg::class_t               q_data,
    output logic                               q_pop,
    input  wire cbt_pkg::cfg_t                 cfg,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [cbt_pkg::POS_W-1:0]          camera_position,
    output logic                               camera_changed,
    output logic signed [cbt_pkg::ANGLE_W-1:0] angle_offset,
    output logic [cbt_pkg::LOST_W-1:0]         lines_lost_count,
    output logic                               route_found
);

    import cbt_pkg::*;

    localparam int CW = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef struct packed {
        logic                   hit;
        logic [COUNT_WIDTH-1:0] cnt;
    } tick_t;

    function automatic tick_t confirm_tick(input logic [COUNT_WIDTH-1:0] cnt,
                                           input logic [LIMIT_W-1:0]     lim);
        tick_t r;
        r.hit = CW'(cnt) >= CW'(lim);
        if (r.hit)
        begin
            r.cnt = '0;
        end
        else if (cnt != CNT_MAX)
        begin
            r.cnt = cnt + 1'b1;
        end
        else
        begin
            r.cnt = cnt;
        end
        return r;
    endfunction

    logic [POS_W-1:0]       cam_reg;
    logic [POS_W-1:0]       route_reg;
    logic [COUNT_WIDTH-1:0] confirm_reg;
    logic [COUNT_WIDTH-1:0] wait_reg;
    logic [LOST_W-1:0]      lost_reg;
    logic                   found_reg;
    logic                   changed_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                   out_valid_reg;

    logic [POS_W-1:0]       cam_next;
    logic [POS_W-1:0]       route_next;
    logic [COUNT_WIDTH-1:0] confirm_next;
    logic [COUNT_WIDTH-1:0] wait_next;
    logic [LOST_W-1:0]      lost_next;
    logic                   found_next;
    logic                   changed_next;
    logic signed [ANGLE_W-1:0] angle_next;

    logic [COUNT_WIDTH-1:0] wait_load;
    logic [COUNT_WIDTH-1:0] confirm_mid;
    logic [POS_W-1:0]       dec;
    tick_t                  t_first;
    tick_t                  t_second;
    logic                   l_ok;
    logic                   r_ok;
    logic                   advance;

    assign wait_load = (CW'(cfg.change_wait_limit) > CW'(CNT_MAX))
                       ? CNT_MAX : COUNT_WIDTH'(cfg.change_wait_limit);

    assign advance = !q_empty && (!out_valid_reg || pop);
    assign q_pop   = advance;

    always_comb
    begin
        cam_next     = cam_reg;
        route_next   = route_reg;
        confirm_next = confirm_reg;
        wait_next    = wait_reg;
        lost_next    = lost_reg;
        found_next   = found_reg;
        changed_next = 1'b0;
        dec          = DEC_NONE;
        confirm_mid  = confirm_reg;
        t_first      = confirm_tick(confirm_reg, cfg.confirm_limit);
        t_second     = t_first;
        l_ok         = 1'b0;
        r_ok         = 1'b0;

        if (!q_data.left_found && !q_data.right_found)
        begin
            if (lost_reg != {LOST_W{1'b1}})
            begin
                lost_next = lost_reg + 1'b1;
            end
        end
        else
        begin
            if (found_reg && cfg.bend_check_enable)
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - 1'b1;
                end
                else if (cam_reg == POS_LEFT || cam_reg == POS_RIGHT)
                begin
                    // back to straight needs both lines steep enough
                    if (q_data.left_found && q_data.right_found &&
                        (route_reg == POS_LEFT || route_reg == POS_RIGHT))
                    begin
                        l_ok = q_data.left_undef ||
                               ((route_reg == POS_LEFT) ? q_data.left_above_lower
                                                        : q_data.left_above_upper);
                        r_ok = q_data.right_undef ||
                               ((route_reg == POS_LEFT) ? q_data.right_above_upper
                                                        : q_data.right_above_lower);
                        if (l_ok && r_ok)
                        begin
                            confirm_next = t_first.cnt;
                            if (t_first.hit)
                            begin
                                dec = POS_STRAIGHT;
                            end
                        end
                    end
                end
                else
                begin
                    // left bend from the right line, then right bend from the left line
                    if (q_data.right_found && !q_data.right_undef)
                    begin
                        if (q_data.right_below_bend)
                        begin
                            confirm_mid = t_first.cnt;
                            if (t_first.hit)
                            begin
                                dec = POS_LEFT;
                            end
                        end
                        else
                        begin
                            confirm_mid = '0;
                        end
                    end
                    confirm_next = confirm_mid;
                    t_second     = confirm_tick(confirm_mid, cfg.confirm_limit);
                    if (dec == DEC_NONE && q_data.left_found && !q_data.left_undef)
                    begin
                        if (q_data.left_below_bend)
                        begin
                            confirm_next = t_second.cnt;
                            if (t_second.hit)
                            begin
                                dec = POS_RIGHT;
                            end
                        end
                        else
                        begin
                            confirm_next = '0;
                        end
                    end
                end

                if (dec != DEC_NONE)
                begin
                    cam_next     = dec;
                    route_next   = dec;
                    changed_next = 1'b1;
                    wait_next    = wait_load;
                end
            end
            found_next = 1'b1;
            lost_next  = '0;
        end

        case (cam_next)
            POS_LEFT:  angle_next = ANGLE_W'(0) - ANGLE_W'(cfg.cam_angle_offset);
            POS_RIGHT: angle_next = ANGLE_W'(cfg.cam_angle_offset);
            default:   angle_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg       <= POS_STRAIGHT;
            route_reg     <= POS_STRAIGHT;
            confirm_reg   <= '0;
            wait_reg      <= '0;
            lost_reg      <= '0;
            found_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            angle_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                cam_reg       <= cam_next;
                route_reg     <= route_next;
                confirm_reg   <= confirm_next;
                wait_reg      <= wait_next;
                lost_reg      <= lost_next;
                found_reg     <= found_next;
                changed_reg   <= changed_next;
                angle_reg     <= angle_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty            = !out_valid_reg;
    assign camera_position  = cam_reg;
    assign camera_changed   = changed_reg;
    assign angle_offset     = angle_reg;
    assign lines_lost_count = lost_reg;
    assign route_found      = found_reg;

endmodule

`default_nettype wire

>>> sv/camera_bend_tracking_fsm.sv
// camera_bend_tracking_fsm: top level, configuration registers and the
// front, queue and back parts; depends on cbt_pkg, cbt_front, cbt_queue, cbt_back
//
// usage
//   input side is a queue: a frame summary is taken at a clock edge with push
//   high and full low. result side is a queue too: the oldest result is on the
//   result ports while empty is low and leaves at an edge with pop high.
//   one result per frame, in order.
//   a frame is registered in the front record, then in a queue entry, then in the
//   result register; throughput is one frame per cycle while the result side
//   is drained, as the back part updates its state and result once per frame.
//   the front registers and classifies slopes, a two-entry queue decouples it
//   from the back part, which owns the tracking state and the result register.
//   when pop stays low, the result register holds, the queue fills, then the
//   front stage holds and full rises; nothing is dropped.
//   reset clears all state: camera straight, counters zero, no route seen, and
//   loads the register defaults. configuration writes take effect at once and
//   are meant for idle periods only.
`default_nettype none

module camera_bend_tracking_fsm #(
    parameter int SLOPE_WIDTH = cbt_pkg::SLOPE_WIDTH_DEF,
    parameter int COUNT_WIDTH = cbt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [cbt_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [cbt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              left_found,
    input  wire logic                              right_found,
    input  wire logic signed [SLOPE_WIDTH-1:0]     left_slope,
    input  wire logic signed [SLOPE_WIDTH-1:0]     right_slope,
    input  wire logic                              left_slope_undefined,
    input  wire logic                              right_slope_undefined,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [cbt_pkg::POS_W-1:0]              camera_position,
    output logic                                   camera_changed,
    output logic signed [cbt_pkg::ANGLE_W-1:0]     angle_offset,
    output logic [cbt_pkg::LOST_W-1:0]             lines_lost_count,
    output logic                                   route_found
);

    import cbt_pkg::*;

    cfg_t   cfg_reg;
    logic   q_in_push;
    class_t q_in_data;
    logic   q_full;
    logic   q_pop;
    class_t q_out_data;
    logic   q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bend_left_thr      <= THR_W'(4096);
            cfg_reg.bend_right_thr     <= THR_W'(4096);
            cfg_reg.straight_upper_thr <= THR_W'(6144);
            cfg_reg.straight_lower_thr <= THR_W'(4096);
            cfg_reg.confirm_limit      <= LIMIT_W'(3);
            cfg_reg.change_wait_limit  <= LIMIT_W'(5);
            cfg_reg.cam_angle_offset   <= OFFSET_W'(10);
            cfg_reg.bend_check_enable  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_BEND_LEFT_THR:      cfg_reg.bend_left_thr      <= cfg_data[THR_W-1:0];
                REG_BEND_RIGHT_THR:     cfg_reg.bend_right_thr     <= cfg_data[THR_W-1:0];
                REG_STRAIGHT_UPPER_THR: cfg_reg.straight_upper_thr <= cfg_data[THR_W-1:0];
                REG_STRAIGHT_LOWER_THR: cfg_reg.straight_lower_thr <= cfg_data[THR_W-1:0];
                REG_CONFIRM_LIMIT:      cfg_reg.confirm_limit      <= cfg_data[LIMIT_W-1:0];
                REG_CHANGE_WAIT_LIMIT:  cfg_reg.change_wait_limit  <= cfg_data[LIMIT_W-1:0];
                REG_CAM_ANGLE_OFFSET:   cfg_reg.cam_angle_offset   <= cfg_data[OFFSET_W-1:0];
                REG_BEND_CHECK_ENABLE:  cfg_reg.bend_check_enable  <= cfg_data[0];
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    cbt_front #(
        .SLOPE_WIDTH (SLOPE_WIDTH)
    ) u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .push                  (push),
        .full                  (full),
        .left_found            (left_found),
        .right_found           (right_found),
        .left_slope            (left_slope),
        .right_slope           (right_slope),
        .left_slope_undefined  (left_slope_undefined),
        .right_slope_undefined (right_slope_undefined),
        .cfg                   (cfg_reg),
        .q_full                (q_full),
        .q_push                (q_in_push),
        .q_data                (q_in_data)
    );

    cbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_in_push),
        .data_in  (q_in_data),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out_data),
        .empty    (q_empty)
    );

    cbt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_data           (q_out_data),
        .q_pop            (q_pop),
        .cfg              (cfg_reg),
        .pop              (pop),
        .empty            (empty),
        .camera_position  (camera_position),
        .camera_changed   (camera_changed),
        .angle_offset     (angle_offset),
        .lines_lost_count (lines_lost_count),
        .route_found      (route_found)
    );

    // a valid result never carries the no-decision code
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> camera_position != DEC_NONE)
        else $error("result with invalid camera position");

    // straight camera means no angle correction
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && camera_position == POS_STRAIGHT) |-> angle_offset == '0)
        else $error("angle offset while camera straight");

    // a zero lost count on a result means a line was seen in that frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && lines_lost_count == '0) |-> route_found)
        else $error("lost count zero without a route");

    // the front stage only holds off input while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("input blocked with queue space left");

endmodule

`default_nettype wire
